[design/bba_pkg.sv]
package bba_pkg;

   localparam int BLOCK_COUNT = 1024;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int NUM_WORDS   = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
   localparam int WA_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int FF_W        = $clog2(BLOCK_COUNT + 1);
   localparam int IDX_W       = 10;
   localparam int LAST_BITS   = BLOCK_COUNT - (NUM_WORDS - 1) * WORD_W;

   localparam logic [WORD_W-1:0] LAST_MASK =
      (LAST_BITS == WORD_W) ? {WORD_W{1'b1}}
                            : WORD_W'((64'd1 << LAST_BITS) - 64'd1);
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOT_USED = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_SCAN_FETCH,
      S_SCAN_CHECK,
      S_DONE
   } state_type;

   // position of the lowest set bit, zero when none
   function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] vec);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (vec[i]) pos = BIT_W'(i);
      end
      return pos;
   endfunction

endpackage

[design/bitmap_block_allocator.sv]
// release: fetch, check and done states lie between accept and result; allocate
//   adds a scan fetch and scan check per further map word; a full pointer skips to done
// throughput: one request at a time; the next is taken once the state returns
//   to idle; map rows are read one at a time through the single read port
// reset: synchronous, active high; afterwards a clearing pass zeroes the map
//   one row at a time, with req_tready low until it ends
module bitmap_block_allocator
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // block_index [9:0], zero [15:10]
   input  logic [0:0]  req_tuser,   // func [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status [1:0], granted_block [11:2], zero [15:12]
);

   // used map, one bit per block, one word per row
   logic [WORD_W-1:0] map_mem [NUM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [WA_W-1:0]   addr_ff, addr_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              func_ff, func_in;
   logic [FF_W-1:0]   next_free_ff, next_free_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic [IDX_W-1:0]  grant_ff, grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_grant_ff, rsp_grant_in;

   logic [31:0]       ff_wide;
   logic [31:0]       idx_wide;
   logic [WORD_W-1:0] word_mask;
   logic [WORD_W-1:0] onehot;
   logic [WORD_W-1:0] free_bits;
   logic              req_beat;

   assign req_beat   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_grant_ff, rsp_status_ff};

   assign ff_wide   = 32'(next_free_ff);
   assign idx_wide  = 32'(req_tdata[IDX_W-1:0]);
   // bits of the current row that are real blocks
   assign word_mask = (addr_ff == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};
   assign onehot    = WORD_W'(1) << bit_ff;

   // map storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) map_mem[addr_ff] <= wr_data;
      rd_data_ff <= map_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         addr_ff       <= '0;
         next_free_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         next_free_ff  <= next_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bit_ff        <= bit_in;
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      bit_in        = bit_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      next_free_in  = next_free_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      wr_data       = '0;
      free_bits     = '0;

      case (state_ff)
         // zero one map row per cycle after reset
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + WA_W'(1);
            end
         end

         S_IDLE: begin
            if (req_beat) begin
               func_in  = req_tuser[0];
               idx_in   = req_tdata[IDX_W-1:0];
               grant_in = '0;
               if (req_tuser[0] == FUNC_ALLOC) begin
                  addr_in = WA_W'(ff_wide >> BIT_W);
                  bit_in  = ff_wide[BIT_W-1:0];
                  if (ff_wide >= 32'(BLOCK_COUNT)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_FETCH;
                  end
               end else begin
                  addr_in = WA_W'(idx_wide >> BIT_W);
                  bit_in  = idx_wide[BIT_W-1:0];
                  if (idx_wide >= 32'(BLOCK_COUNT)) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            end
         end

         // row read in flight
         S_FETCH: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (func_ff == FUNC_ALLOC) begin
               if ((rd_data_ff & onehot) != '0) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  wr_en     = 1'b1;
                  wr_data   = rd_data_ff | onehot;
                  status_in = ST_OK;
                  grant_in  = IDX_W'(ff_wide);
                  // free blocks above the grant in the same row
                  free_bits = ~wr_data & word_mask
                              & ((({WORD_W{1'b1}}) << bit_ff) << 1);
                  if (free_bits != '0) begin
                     next_free_in = FF_W'({addr_ff, lowest_one(free_bits)});
                     state_in     = S_DONE;
                  end else if (addr_ff == LAST_WORD) begin
                     next_free_in = FF_W'(BLOCK_COUNT);
                     state_in     = S_DONE;
                  end else begin
                     addr_in  = addr_ff + WA_W'(1);
                     state_in = S_SCAN_FETCH;
                  end
               end
            end else begin
               if ((rd_data_ff & onehot) == '0) begin
                  status_in = ST_NOT_USED;
               end else begin
                  wr_en     = 1'b1;
                  wr_data   = rd_data_ff & ~onehot;
                  status_in = ST_OK;
                  if (32'(next_free_ff) > 32'(idx_ff)) begin
                     next_free_in = FF_W'(idx_ff);
                  end
               end
               state_in = S_DONE;
            end
         end

         S_SCAN_FETCH: begin
            state_in = S_SCAN_CHECK;
         end

         // one row per pass through the shared read port
         S_SCAN_CHECK: begin
            free_bits = ~rd_data_ff & word_mask;
            if (free_bits != '0) begin
               next_free_in = FF_W'({addr_ff, lowest_one(free_bits)});
               state_in     = S_DONE;
            end else if (addr_ff == LAST_WORD) begin
               next_free_in = FF_W'(BLOCK_COUNT);
               state_in     = S_DONE;
            end else begin
               addr_in  = addr_ff + WA_W'(1);
               state_in = S_SCAN_FETCH;
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_grant_in  = grant_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[design/bba_checker.sv]
module bba_checker
   import bba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a failed request carries no block number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[11:2] == '0)
      else $error("nonzero grant on failed request");

   // busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // clearing pass follows reset
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("not held off after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/bitmap_block_allocator_test.sv]
`timescale 1ns / 1ps

module bitmap_block_allocator_test;
   import bba_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 80;    // longest allocate scan plus margin
   localparam int RANDOM_ITEMS = 1225;

   // expected response packed as {granted_block, status}
   typedef logic [IDX_W+1:0] reply_type;

   // predicts allocator replies and checks them in order
   class alloc_scoreboard;
      bit        used_map[BLOCK_COUNT];
      int        next_free;
      int        used_count;
      int        peak_used;
      reply_type reply_q[$];
      int        errors;
      int        n_grant, n_full, n_freed, n_not_used, n_range;

      function new();
         foreach (used_map[i]) used_map[i] = 1'b0;
         next_free  = 0;
         used_count = 0;
         peak_used  = 0;
         errors     = 0;
         n_grant    = 0;
         n_full     = 0;
         n_freed    = 0;
         n_not_used = 0;
         n_range    = 0;
      endfunction

      // accepted request beat: update the map and queue the reply it causes
      function void note_request(logic func, logic [IDX_W-1:0] idx);
         logic [1:0]       status;
         logic [IDX_W-1:0] grant;
         int               next;
         status = ST_OK;
         grant  = '0;
         if (func == FUNC_ALLOC) begin
            if (next_free >= BLOCK_COUNT || used_map[next_free]) begin
               status = ST_FULL;
               n_full++;
            end else begin
               grant = IDX_W'(next_free);
               used_map[next_free] = 1'b1;
               used_count++;
               if (used_count > peak_used) peak_used = used_count;
               // pointer moves to the next free block above, or parks at the end
               next = BLOCK_COUNT;
               for (int b = next_free + 1; b < BLOCK_COUNT; b++) begin
                  if (!used_map[b]) begin
                     next = b;
                     break;
                  end
               end
               next_free = next;
               n_grant++;
            end
         end else if (int'(idx) >= BLOCK_COUNT) begin
            status = ST_RANGE;
            n_range++;
         end else if (!used_map[idx]) begin
            status = ST_NOT_USED;
            n_not_used++;
         end else begin
            used_map[idx] = 1'b0;
            used_count--;
            if (next_free > int'(idx)) next_free = int'(idx);
            n_freed++;
         end
         reply_q.push_back({grant, status});
      endfunction

      function void report(string what, logic [IDX_W+1:0] exp_v, logic [IDX_W+1:0] act_v);
         errors++;
         if (errors <= 10)
            $display("%t mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
      endfunction

      // accepted response beat: compare with the oldest expected reply
      function void check_response(logic [15:0] data);
         reply_type exp_r;
         if (reply_q.size() == 0) begin
            report("unexpected response", '0, data[IDX_W+1:0]);
            return;
         end
         exp_r = reply_q.pop_front();
         if (data[1:0] !== exp_r[1:0])
            report("status", exp_r[1:0], data[1:0]);
         if (data[IDX_W+1:2] !== exp_r[IDX_W+1:2])
            report("granted_block", exp_r[IDX_W+1:2], data[IDX_W+1:2]);
      endfunction

      // some block currently in use, or -1 when the map is empty
      function int pick_used();
         int start;
         if (used_count == 0) return -1;
         start = $urandom_range(BLOCK_COUNT - 1);
         for (int k = 0; k < BLOCK_COUNT; k++) begin
            if (used_map[(start + k) % BLOCK_COUNT]) return (start + k) % BLOCK_COUNT;
         end
         return -1;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // block_index [9:0], zero [15:10]
   logic [0:0]  req_tuser = '0;   // func [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // status [1:0], granted_block [11:2], zero [15:12]

   alloc_scoreboard sb = new();

   bit calm = 1'b0;               // no idling on either side while set
   int idle_cycles = 0;

   bitmap_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // response side: random backpressure, none during the calm stretch
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || ($urandom_range(99) >= 34);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d replies outstanding",
                  idle_cycles, sb.reply_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one request beat and hold it until it is taken
   task automatic send_request(logic func, logic [IDX_W-1:0] idx);
      if (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(16 - IDX_W){1'b0}}, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, idx);
   endtask

   task automatic send_alloc();
      send_request(FUNC_ALLOC, IDX_W'($urandom));
   endtask

   task automatic send_release(logic [IDX_W-1:0] idx);
      send_request(FUNC_RELEASE, idx);
   endtask

   initial begin
      int pick;
      int alloc_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: releases of free blocks at both ends, allocate order,
      // pointer lowered by a release below it, double release
      // (an out-of-range index cannot be formed with a 10-bit field here)
      send_release('0);
      send_release(IDX_W'(BLOCK_COUNT - 1));
      repeat (4) send_alloc();
      send_release(IDX_W'(1));
      send_release(IDX_W'(1));
      send_alloc();
      send_alloc();
      send_release(IDX_W'(0));
      send_release(IDX_W'(3));
      send_alloc();
      send_alloc();
      send_alloc();
      send_release(10'h2AA);
      send_release(10'h155);
      send_release(IDX_W'(2));
      send_alloc();

      // random: mostly allocates until the map fills and reports full,
      // then a release-heavy tail that reopens holes below the pointer
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 300 && i < 600);
         alloc_pct = (i < 1150) ? 97 : 35;
         if ($urandom_range(99) < alloc_pct) begin
            send_alloc();
         end else begin
            pick = sb.pick_used();
            if (pick >= 0 && $urandom_range(99) < 80)
               send_release(IDX_W'(pick));
            else
               send_release(IDX_W'($urandom));
         end
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (sb.reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d grants, %0d full replies, %0d frees, %0d frees of unused blocks",
               sb.n_grant, sb.n_full, sb.n_freed, sb.n_not_used);
      $display("map peaked at %0d of %0d blocks in use", sb.peak_used, BLOCK_COUNT);
      if (sb.errors == 0 && sb.reply_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d replies missing", sb.errors, sb.reply_q.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
